[rtl/scpw_pkg.sv]
// Shared types and constants for the sparse column pointer walker.
// Used by the top unit and scpw_walk; depends on nothing else.
package scpw_pkg;

   // Pointer table geometry; the table is split into even and odd banks
   localparam int POINTER_WORDS    = 1024;
   localparam int BANK_WORDS       = POINTER_WORDS / 2;
   localparam int BANK_AW          = $clog2(BANK_WORDS);
   localparam int ENTRIES_PER_LINE = 8;

   localparam logic [15:0] LINE_NONE = 16'hffff;

   // Operation codes of an input item
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   // Upstream slot carried by a tick item
   typedef struct packed {
      logic        empty;
      logic [8:0]  odd_column;
      logic [8:0]  even_column;
      logic        parity;
      logic [15:0] activation;
   } slot_type;

   // One result item
   typedef struct packed {
      logic        entry_valid;
      logic [15:0] entry_address;
      logic [15:0] line_address;
      logic [7:0]  line_offset;
      logic        line_fetch;
      logic        column_done;
      logic        pointer_request;
      logic [15:0] value_out;
   } result_type;

endpackage

[rtl/sparse_column_pointer_walker_unit.sv]
// Top level of the sparse column pointer walker: input stage, pointer banks,
// walk logic and result register. Depends on scpw_pkg, scpw_ram, scpw_walk.
//
// Usage:
//   The req_ channel carries one item per accepted edge (req_valid high,
//   req_stall low). A load item (req_operation = 1) writes one pointer word
//   into the even or odd bank and gives no result. A tick item
//   (req_operation = 0) carries one upstream slot and gives exactly one
//   result item on the rsp_ channel, taken when rsp_valid is high and
//   rsp_stall is low.
//   Result path: the edge that accepts a tick captures the slot and the bank
//   read data; the edge that advances the tick out of the input stage
//   registers the result.
//   Throughput: one item per clock cycle unless stalled, loads and ticks
//   alike. The input stage and result register each move one tick per cycle,
//   and a bank read issued as a tick is accepted is ready by the next edge.
//   Stall: while rsp_stall holds a result, the tick behind it waits in the
//   input stage and req_stall rises; nothing is lost or reordered.
//   Reset (synchronous, active high) empties both stages and puts the walk
//   state to its idle values; the pointer banks are not cleared and must be
//   loaded before they are read.
module sparse_column_pointer_walker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [9:0]  req_table_index,
   input  logic [15:0] req_table_word,
   input  logic        req_upstream_empty,
   input  logic [8:0]  req_odd_column,
   input  logic [8:0]  req_even_column,
   input  logic        req_column_parity,
   input  logic [15:0] req_activation,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_entry_valid,
   output logic [15:0] rsp_entry_address,
   output logic [15:0] rsp_line_address,
   output logic [7:0]  rsp_line_offset,
   output logic        rsp_line_fetch,
   output logic        rsp_column_done,
   output logic        rsp_pointer_request,
   output logic [15:0] rsp_value_out
);
   import scpw_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   slot_type    s1_slot_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  result_ff, walk_result;

   logic        accept, tick_accept, load_accept, advance;
   logic        wr_odd, wr_even;
   logic [BANK_AW-1:0] rd_odd_addr, rd_even_addr;
   logic [15:0] odd_data, even_data;

   // handshake
   assign advance     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign tick_accept = accept && (op_type'(req_operation) == OP_TICK);
   assign load_accept = accept && (op_type'(req_operation) == OP_LOAD)
                        && (32'(req_table_index) < POINTER_WORDS);

   // load writes go to the bank picked by the low index bit
   assign wr_odd  = load_accept && req_table_index[0];
   assign wr_even = load_accept && !req_table_index[0];

   scpw_ram #(.WIDTH(16), .DEPTH(BANK_WORDS)) u_odd_bank (
      .clock   (clock),
      .wr_en   (wr_odd),
      .wr_addr (req_table_index[BANK_AW:1]),
      .wr_data (req_table_word),
      .rd_en   (tick_accept),
      .rd_addr (rd_odd_addr),
      .rd_data (odd_data)
   );

   scpw_ram #(.WIDTH(16), .DEPTH(BANK_WORDS)) u_even_bank (
      .clock   (clock),
      .wr_en   (wr_even),
      .wr_addr (req_table_index[BANK_AW:1]),
      .wr_data (req_table_word),
      .rd_en   (tick_accept),
      .rd_addr (rd_even_addr),
      .rd_data (even_data)
   );

   scpw_walk u_walk (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .slot         (s1_slot_ff),
      .odd_data     (odd_data),
      .even_data    (even_data),
      .result       (walk_result),
      .rd_odd_addr  (rd_odd_addr),
      .rd_even_addr (rd_even_addr)
   );

   // input stage holds tick items only
   assign s1_valid_in  = tick_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_slot_ff <= '{
            empty:       req_upstream_empty,
            odd_column:  req_odd_column,
            even_column: req_even_column,
            parity:      req_column_parity,
            activation:  req_activation
         };
      end
      if (advance) begin
         result_ff <= walk_result;
      end
   end

   // result ports
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_entry_valid     = result_ff.entry_valid;
   assign rsp_entry_address   = result_ff.entry_address;
   assign rsp_line_address    = result_ff.line_address;
   assign rsp_line_offset     = result_ff.line_offset;
   assign rsp_line_fetch      = result_ff.line_fetch;
   assign rsp_column_done     = result_ff.column_done;
   assign rsp_pointer_request = result_ff.pointer_request;
   assign rsp_value_out       = result_ff.value_out;

   // checks
   a_fetch_needs_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.line_fetch |-> result_ff.entry_valid)
      else $error("line fetch without a valid entry");

   a_idle_requests: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.entry_valid |-> result_ff.pointer_request)
      else $error("no entry but no pointer request");

   a_advance_presents: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced tick did not reach the result register");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

[rtl/scpw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module scpw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/scpw_walk.sv]
// Walk state and per-tick logic: picks start/end words, steps the entry address,
// splits it into line and offset and computes the next bank read address.
// Depends on scpw_pkg.
module scpw_walk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  scpw_pkg::slot_type            slot,
   input  logic [15:0]                   odd_data,
   input  logic [15:0]                   even_data,
   output scpw_pkg::result_type          result,
   output logic [scpw_pkg::BANK_AW-1:0]  rd_odd_addr,
   output logic [scpw_pkg::BANK_AW-1:0]  rd_even_addr
);
   import scpw_pkg::*;

   logic        read_pending_ff, read_pending_in;
   logic [8:0]  held_odd_ff, held_odd_in;
   logic [8:0]  held_even_ff, held_even_in;
   logic        held_parity_ff, held_parity_in;
   logic [15:0] held_act_ff, held_act_in;
   logic        slot_empty_ff, slot_empty_in;
   logic [15:0] odd_word_ff, odd_word_in;
   logic [15:0] even_word_ff, even_word_in;
   logic [15:0] next_addr_ff, next_addr_in;
   logic        run_finished_ff, run_finished_in;
   logic [15:0] prev_line_ff, prev_line_in;

   logic [15:0] start_word, last_addr, cur_addr, line_addr;
   logic        valid, fetch, done, request;

   // current words: fresh bank data right after a pointer read
   assign odd_word_in  = read_pending_ff ? odd_data  : odd_word_ff;
   assign even_word_in = read_pending_ff ? even_data : even_word_ff;

   // walk logic for this tick
   always_comb begin
      start_word = held_parity_ff ? odd_word_in : even_word_in;
      last_addr  = (held_parity_ff ? even_word_in : odd_word_in) - 16'd1;
      valid      = !((even_word_in == odd_word_in) || slot_empty_ff);
      cur_addr   = run_finished_ff ? start_word : next_addr_ff;
      line_addr  = cur_addr / 16'(ENTRIES_PER_LINE);
      fetch      = valid && (line_addr != prev_line_ff);
      done       = cur_addr == last_addr;
      request    = !valid || done;
   end

   assign result = '{
      entry_valid:     valid,
      entry_address:   cur_addr,
      line_address:    line_addr,
      line_offset:     8'(cur_addr % 16'(ENTRIES_PER_LINE)),
      line_fetch:      fetch,
      column_done:     done,
      pointer_request: request,
      value_out:       held_act_ff
   };

   // next state once the tick leaves the stage
   always_comb begin
      read_pending_in = request && !slot.empty;
      held_odd_in     = held_odd_ff;
      held_even_in    = held_even_ff;
      held_parity_in  = held_parity_ff;
      held_act_in     = held_act_ff;
      slot_empty_in   = slot_empty_ff;
      if (request) begin
         if (!slot.empty) begin
            held_odd_in    = slot.odd_column;
            held_even_in   = slot.even_column;
            held_parity_in = slot.parity;
            held_act_in    = slot.activation;
         end
         slot_empty_in = slot.empty;
      end
      next_addr_in    = valid ? cur_addr + 16'd1 : next_addr_ff;
      run_finished_in = valid ? done : run_finished_ff;
      prev_line_in    = valid ? line_addr : prev_line_ff;
   end

   // bank read address for the next tick: held columns after this tick
   assign rd_odd_addr  = advance ? held_odd_in[BANK_AW-1:0]  : held_odd_ff[BANK_AW-1:0];
   assign rd_even_addr = advance ? held_even_in[BANK_AW-1:0] : held_even_ff[BANK_AW-1:0];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         read_pending_ff <= 1'b0;
         held_odd_ff     <= '0;
         held_even_ff    <= '0;
         held_parity_ff  <= 1'b0;
         held_act_ff     <= '0;
         slot_empty_ff   <= 1'b1;
         odd_word_ff     <= '0;
         even_word_ff    <= '0;
         next_addr_ff    <= '0;
         run_finished_ff <= 1'b1;
         prev_line_ff    <= LINE_NONE;
      end else if (advance) begin
         read_pending_ff <= read_pending_in;
         held_odd_ff     <= held_odd_in;
         held_even_ff    <= held_even_in;
         held_parity_ff  <= held_parity_in;
         held_act_ff     <= held_act_in;
         slot_empty_ff   <= slot_empty_in;
         odd_word_ff     <= odd_word_in;
         even_word_ff    <= even_word_in;
         next_addr_ff    <= next_addr_in;
         run_finished_ff <= run_finished_in;
         prev_line_ff    <= prev_line_in;
      end
   end

endmodule
